>>> hdl/assert_macros.svh
// assert_macros.svh: assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bsfd_pkg.sv
// ---------------------------------------------------------------------------
// bsfd_pkg: shared types and constants
// Parse and sequencer codes, byte ALU ops, register indexes, reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsfd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 32;
  localparam int DATA_W  = 8;
  localparam int IDX_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] DELIM_RST = 8'd126;
  localparam logic [DATA_W-1:0] ESC_RST   = 8'd125;
  localparam logic [DATA_W-1:0] MASK_RST  = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIM = 2'd0,
    REG_ESC   = 2'd1,
    REG_MASK  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    PS_IDLE     = 2'd0,
    PS_START    = 2'd1,
    PS_IN_FRAME = 2'd2,
    PS_ESCAPED  = 2'd3
  } parse_t;

  typedef enum logic [1:0] {
    SEQ_WAIT      = 2'd0,
    SEQ_EXEC      = 2'd1,
    SEQ_DRAIN_RD  = 2'd2,
    SEQ_DRAIN_OUT = 2'd3
  } seq_t;

  typedef enum logic [1:0] {
    ALU_CMP_DELIM = 2'd0,
    ALU_CMP_ESC   = 2'd1,
    ALU_XOR_MASK  = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] delim;
    logic [DATA_W-1:0] esc;
    logic [DATA_W-1:0] mask;
  } cfg_t;

endpackage

>>> hdl/bsfd_ram.sv
// ---------------------------------------------------------------------------
// bsfd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/bsfd_alu.sv
// ---------------------------------------------------------------------------
// bsfd_alu: shared byte unit
// One comparator against delimiter or escape, plus the escape-mask XOR.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsfd_alu
  import bsfd_pkg::*;
(
  input  alu_op_t           op,
  input  cfg_t              cfg,
  input  logic [DATA_W-1:0] a,
  output logic              eq,
  output logic [DATA_W-1:0] result
);

  logic [DATA_W-1:0] b;

  always_comb begin
    b      = cfg.esc;
    result = a;
    unique case (op)
      ALU_CMP_DELIM: b = cfg.delim;
      ALU_CMP_ESC:   b = cfg.esc;
      ALU_XOR_MASK:  result = a ^ cfg.mask;
      default: begin
        b      = cfg.esc;
        result = a;
      end
    endcase
  end

  assign eq = (a == b);

endmodule

>>> hdl/byte_stuffed_frame_deframer.sv
// ---------------------------------------------------------------------------
// byte_stuffed_frame_deframer: delimiter / escape frame stripper
// Takes received bytes, unstuffs them into a frame buffer and drains the
// frame as a run of output beats when the closing delimiter arrives.
// ---------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  in      | in_valid / in_stall (out)  | rx_byte
//  out     | out_valid / out_stall (in) | frame_byte, byte_index, last_byte,
//          |                            | overflowed
//  cfg     | cfg_we                     | cfg_index, cfg_data
//
// Each byte has an accept cycle, where the shared byte unit tests it
//   against the delimiter, then an execute cycle, where the same unit does
//   the escape test or the mask XOR and the buffer is written.
// A closing delimiter then drains the frame: per beat, DRAIN_RD issues the
//   registered RAM read and DRAIN_OUT loads the single output register.
// Reset clears control state only; the frame RAM needs no clearing pass.
// out_stall holds the drain in place; a finished last beat may sit in the
//   output register while the next bytes are taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_stuffed_frame_deframer
  import bsfd_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // config write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  // byte input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    rx_byte,
  // frame output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    frame_byte,
  output logic [IDX_W-1:0]     byte_index,
  output logic                 last_byte,
  output logic                 overflowed
);

  // buffer address and fill-count widths
  localparam int AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_BYTES);

  // config registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delim <= DELIM_RST;
      cfg.esc   <= ESC_RST;
      cfg.mask  <= MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELIM: cfg.delim <= cfg_data;
        REG_ESC:   cfg.esc   <= cfg_data;
        REG_MASK:  cfg.mask  <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // sequencer and parse state
  seq_t   seq, seq_next;
  parse_t parse_state;

  logic [DATA_W-1:0] rx_hold;
  logic              is_delim;     // delimiter test from the accept cycle
  logic [CW-1:0]     byte_count;
  logic              overflow_seen;
  logic [AW-1:0]     drain_idx;

  // shared byte unit
  alu_op_t           alu_op;
  logic [DATA_W-1:0] alu_a;
  logic              alu_eq;
  logic [DATA_W-1:0] alu_res;

  bsfd_alu u_alu (
    .op     (alu_op),
    .cfg    (cfg),
    .a      (alu_a),
    .eq     (alu_eq),
    .result (alu_res)
  );

  // frame buffer
  logic              ram_we;
  logic              ram_rd_en;
  logic [DATA_W-1:0] ram_rd_data;

  bsfd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_FRAME_BYTES),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (byte_count[AW-1:0]),
    .wr_data (alu_res),
    .rd_en   (ram_rd_en),
    .rd_addr (drain_idx),
    .rd_data (ram_rd_data)
  );

  logic in_accept;
  logic do_store;
  logic has_room;
  logic start_drain;
  logic slot_free;
  logic drain_last;

  assign in_accept  = in_valid && !in_stall;
  assign has_room   = (byte_count < MAX_CNT);
  assign slot_free  = !out_valid || !out_stall;
  assign drain_last = ((CW'(drain_idx) + CW'(1)) == byte_count);

  // sequencer outputs
  always_comb begin
    in_stall    = 1'b1;
    alu_op      = ALU_CMP_ESC;
    alu_a       = rx_hold;
    do_store    = 1'b0;
    start_drain = 1'b0;
    ram_rd_en   = 1'b0;
    unique case (seq)
      SEQ_WAIT: begin
        in_stall = 1'b0;
        alu_op   = ALU_CMP_DELIM;
        alu_a    = rx_byte;
      end
      SEQ_EXEC: begin
        alu_op = (parse_state == PS_ESCAPED) ? ALU_XOR_MASK : ALU_CMP_ESC;
        unique case (parse_state)
          PS_IDLE:     do_store = 1'b0;
          PS_START:    do_store = !is_delim;
          // escape test wins over the delimiter test
          PS_IN_FRAME: begin
            do_store    = !alu_eq && !is_delim;
            start_drain = !alu_eq && is_delim && (byte_count != '0);
          end
          PS_ESCAPED:  do_store = 1'b1;
        endcase
      end
      SEQ_DRAIN_RD:  ram_rd_en = 1'b1;
      SEQ_DRAIN_OUT: ram_rd_en = 1'b0;
    endcase
  end

  assign ram_we = do_store && has_room;

  // sequencer next state
  always_comb begin
    seq_next = seq;
    unique case (seq)
      SEQ_WAIT:      if (in_accept) seq_next = SEQ_EXEC;
      SEQ_EXEC:      seq_next = start_drain ? SEQ_DRAIN_RD : SEQ_WAIT;
      SEQ_DRAIN_RD:  seq_next = SEQ_DRAIN_OUT;
      SEQ_DRAIN_OUT: begin
        if (slot_free) begin
          seq_next = drain_last ? SEQ_WAIT : SEQ_DRAIN_RD;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq           <= SEQ_WAIT;
      parse_state   <= PS_IDLE;
      byte_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      seq <= seq_next;
      if (seq == SEQ_EXEC) begin
        unique case (parse_state)
          PS_IDLE: begin
            if (is_delim) begin
              byte_count    <= '0;
              overflow_seen <= 1'b0;
              parse_state   <= PS_START;
            end
          end
          PS_START: if (!is_delim) parse_state <= PS_IN_FRAME;
          PS_IN_FRAME: begin
            if (alu_eq) begin
              parse_state <= PS_ESCAPED;
            end else if (is_delim) begin
              parse_state <= PS_IDLE;
            end
          end
          PS_ESCAPED: parse_state <= PS_IN_FRAME;
        endcase
        // full buffer: byte dropped, loss flagged, parse still advances
        if (do_store) begin
          if (has_room) begin
            byte_count <= byte_count + CW'(1);
          end else begin
            overflow_seen <= 1'b1;
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rx_hold  <= rx_byte;
      is_delim <= alu_eq;
    end
    if (start_drain) begin
      drain_idx <= '0;
    end else if (seq == SEQ_DRAIN_OUT && slot_free && !drain_last) begin
      drain_idx <= drain_idx + AW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq == SEQ_DRAIN_OUT && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq == SEQ_DRAIN_OUT && slot_free) begin
      frame_byte <= ram_rd_data;
      byte_index <= IDX_W'(drain_idx);
      last_byte  <= drain_last;
      overflowed <= overflow_seen;
    end
  end

endmodule

>>> hdl/bsfd_checker.sv
// ---------------------------------------------------------------------------
// bsfd_checker: port-level checks for the deframer
// Watches the top-level ports only; bound to the top level below.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsfd_checker
  import bsfd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [DATA_W-1:0]    cfg_data,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [DATA_W-1:0]    rx_byte,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [DATA_W-1:0]    frame_byte,
  input logic [IDX_W-1:0]     byte_index,
  input logic                 last_byte,
  input logic                 overflowed
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  // stalled output beat holds
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(byte_index) && $stable(last_byte) && $stable(overflowed), "output beat changed while stalled")

  // input stalls after every taken byte, for its execute step
  `ASSERT_CLK(a_busy_after_in, clk, rst, in_beat |=> in_stall, "input taken in the execute cycle")

  // no input while a frame is mid-drain
  `ASSERT_CLK(a_drain_blocks_in, clk, rst, out_valid && !last_byte |-> in_stall, "input open during drain")

  // drained beats count up by one within a frame
  `ASSERT_CLK(a_index_step, clk, rst, out_beat && !last_byte |=> !out_valid || (byte_index == $past(byte_index) + 5'd1), "byte index skipped")

  // a new frame starts at index zero
  `ASSERT_CLK(a_index_first, clk, rst, out_beat && last_byte |=> !out_valid || (byte_index == '0), "frame does not start at index zero")

endmodule

bind byte_stuffed_frame_deframer bsfd_checker u_bsfd_checker (.*);
